// ===== design/ahs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahs_pkg: shared types and constants of the altitude hold setpoint block
// Register map, configuration struct, sequencer states, fixed widths and the
// saturation helper used by the top level.
// ----------------------------------------------------------------------------
package ahs_pkg;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_SENS   = 3'd0,
      CSR_TO_EN  = 3'd1,
      CSR_ALPHA  = 3'd2,
      CSR_ADJUST = 3'd3,
      CSR_THRESH = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [30:0] sens;
      logic        to_en;
      logic [15:0] alpha;
      logic [30:0] adjust;
      logic [16:0] thresh;
   } cfg_type;

   // register reset values
   localparam logic [30:0] SENS_RST   = 31'd13107200;
   localparam logic        TO_EN_RST  = 1'b1;
   localparam logic [15:0] ALPHA_RST  = 16'd64225;
   localparam logic [30:0] ADJUST_RST = 31'd98304;
   localparam logic [16:0] THRESH_RST = 17'd63570;

   // state reset values
   localparam logic [31:0] TARGET_RST = 32'hFFFF_0000;

   // stream widths
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 40;

   // serial divider: 48-bit dividend, 31-bit divisor, one quotient bit per cycle
   localparam int unsigned DIV_N_W   = 48;
   localparam int unsigned DIV_D_W   = 31;
   localparam int unsigned DIV_STEPS = DIV_N_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // serial multiplier: 31-bit multiplicand, 17-bit multiplier, one bit per cycle
   localparam int unsigned MUL_A_W   = 31;
   localparam int unsigned MUL_B_W   = 17;
   localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int unsigned MUL_STEPS = MUL_B_W;
   localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

   // Q1.16 one and rounding half
   localparam logic [16:0] Q_ONE  = 17'd65536;
   localparam logic [15:0] Q_HALF = 16'd32768;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_RUN,
      ST_MUL1_GO,
      ST_MUL1_RUN,
      ST_MUL2_GO,
      ST_MUL2_RUN,
      ST_FIN
   } state_type;

   // clamp a 36-bit signed value into the signed 32-bit range
   function automatic logic [31:0] sat36(input logic [35:0] v);
      logic [31:0] r;
      if (!v[35] && (v[34:31] != 4'b0000)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[35] && (v[34:31] != 4'b1111)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/altitude_hold_setpoint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_hold_setpoint: altitude hold target with automatic take-off climb
// One item per control tick on req_*, one result item per tick on rsp_*.
// Settings are written over the csr_* register port; the user must write them
// only while the block is idle, which the block itself does not enforce.
//
// Path from input accept to result valid: straight to the output register
// when hold is off or on the activation tick without take-off, through two
// passes of the 17-step serial multiplier while a take-off climb runs, and
// through the 48-step serial divider when the pilot climb command is applied.
// One item is in work at a time; the next item is taken once the current
// result has been handed to the output register.
// Reset loads register defaults, target -1 m, clears the edge detector and
// take-off state, and empties the output register.
// A stalled receiver holds the result in the output register; a new item may
// still be accepted and worked on, and it waits at its end until the output
// register frees up.
// ----------------------------------------------------------------------------
module altitude_hold_setpoint (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] hold_request, [32:1] pilot_climb, [64:33] measured_alt,
   // [65] at_rest, [66] tumbled, [71:67] zero
   input  logic [ahs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hold_active, [32:1] setpoint_alt, [33] is_update,
   // [34] takeoff_running, [39:35] zero
   output logic [ahs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ahs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ahs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ahs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   ahs_pkg::cfg_type   cfg;
   ahs_pkg::state_type state_ff, state_in;

   // input fields
   logic        in_req, in_rest, in_tumb;
   logic [31:0] in_climb, in_meas;
   logic        accept, just_w, start_w;

   // item state
   logic        req_ff, req_in;
   logic        upd_ff, upd_in;
   logic [31:0] climb_ff, climb_in;

   // model state
   logic        prev_ff, prev_in;
   logic [31:0] target_ff, target_in;
   logic        active_ff, active_in;
   logic [31:0] base_ff, base_in;
   logic [16:0] prog_ff, prog_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ahs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // sequencer outputs
   logic div_start, mul_start, mul_sel_adj, out_load;

   // arithmetic units
   logic [ahs_pkg::DIV_N_W-1:0] div_n, quo;
   logic [ahs_pkg::DIV_D_W-1:0] sens_eff;
   logic                        div_done;
   logic [ahs_pkg::MUL_A_W-1:0] mul_a;
   logic [ahs_pkg::MUL_P_W-1:0] prod;
   logic                        mul_done;

   // result arithmetic
   logic [31:0] climb_abs;
   logic [33:0] qmag;
   logic [35:0] delta, div_sum;
   logic [16:0] one_minus;
   logic [34:0] psum;
   logic [16:0] new_prog;
   logic [48:0] lsum;
   logic [32:0] lift;
   logic [35:0] lift_sum;

   ahs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the input item
   assign in_req   = req_tdata[0];
   assign in_climb = req_tdata[32:1];
   assign in_meas  = req_tdata[64:33];
   assign in_rest  = req_tdata[65];
   assign in_tumb  = req_tdata[66];
   assign accept   = req_tvalid & req_tready;

   // rising edge of the request and take-off start condition
   assign just_w  = in_req & ~prev_ff;
   assign start_w = just_w & ~active_ff & cfg.to_en & in_rest & ~in_tumb;

   // divider operands: magnitude of climb in Q16.16 scaled by one
   assign climb_abs = climb_ff[31] ? (~climb_ff + 32'd1) : climb_ff;
   assign div_n     = {climb_abs, 16'd0};
   assign sens_eff  = (cfg.sens == '0) ? 31'd1 : cfg.sens;

   ahs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (sens_eff),
      .done     (div_done),
      .quotient (quo)
   );

   // multiplier shared by the progress step and the lift step
   assign mul_a = mul_sel_adj ? cfg.adjust : {15'd0, cfg.alpha};

   ahs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (prog_ff),
      .done    (mul_done),
      .product (prod)
   );

   // pilot change: clamp quotient so the sum stays in 36 bits, then saturate
   assign qmag    = (quo[47:33] != '0) ? 34'h2_0000_0000 : {1'b0, quo[32:0]};
   assign delta   = climb_ff[31] ? (36'd0 - {2'b00, qmag}) : {2'b00, qmag};
   assign div_sum = {{4{target_ff[31]}}, target_ff} + delta;

   // progress step with round half up
   assign one_minus = ahs_pkg::Q_ONE - {1'b0, cfg.alpha};
   assign psum      = {1'b0, prod[33:0]} + {2'b00, one_minus, 16'd0}
                    + {19'd0, ahs_pkg::Q_HALF};
   assign new_prog  = psum[32:16];

   // lift with round half up, added to the base altitude
   assign lsum     = {1'b0, prod} + {33'd0, ahs_pkg::Q_HALF};
   assign lift     = lsum[48:16];
   assign lift_sum = {{4{base_ff[31]}}, base_ff} + {3'd0, lift};

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ahs_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (!in_req) begin
                  state_in = ahs_pkg::ST_FIN;
               end else if (just_w) begin
                  state_in = (active_ff | start_w) ? ahs_pkg::ST_MUL1_GO : ahs_pkg::ST_FIN;
               end else begin
                  state_in = active_ff ? ahs_pkg::ST_MUL1_GO : ahs_pkg::ST_DIV_GO;
               end
            end
         end
         ahs_pkg::ST_DIV_GO:   state_in = ahs_pkg::ST_DIV_RUN;
         ahs_pkg::ST_DIV_RUN:  if (div_done) state_in = ahs_pkg::ST_FIN;
         ahs_pkg::ST_MUL1_GO:  state_in = ahs_pkg::ST_MUL1_RUN;
         ahs_pkg::ST_MUL1_RUN: if (mul_done) state_in = ahs_pkg::ST_MUL2_GO;
         ahs_pkg::ST_MUL2_GO:  state_in = ahs_pkg::ST_MUL2_RUN;
         ahs_pkg::ST_MUL2_RUN: if (mul_done) state_in = ahs_pkg::ST_FIN;
         ahs_pkg::ST_FIN:      if (out_load) state_in = ahs_pkg::ST_IDLE;
         default:              state_in = ahs_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready  = 1'b0;
      div_start   = 1'b0;
      mul_start   = 1'b0;
      mul_sel_adj = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ahs_pkg::ST_IDLE:    req_tready = 1'b1;
         ahs_pkg::ST_DIV_GO:  div_start  = 1'b1;
         ahs_pkg::ST_MUL1_GO: mul_start  = 1'b1;
         ahs_pkg::ST_MUL2_GO: begin
            mul_start   = 1'b1;
            mul_sel_adj = 1'b1;
         end
         ahs_pkg::ST_FIN:     out_load = ~rsp_valid_ff | rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ahs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold and take-off state updates
   always_comb begin
      req_in    = req_ff;
      upd_in    = upd_ff;
      climb_in  = climb_ff;
      prev_in   = prev_ff;
      target_in = target_ff;
      active_in = active_ff;
      base_in   = base_ff;
      prog_in   = prog_ff;
      if (accept) begin
         req_in   = in_req;
         upd_in   = in_req & ~just_w;
         climb_in = in_climb;
         prev_in  = in_req;
         if (just_w) begin
            target_in = in_meas;
         end
         if (start_w) begin
            active_in = 1'b1;
            base_in   = in_meas;
            prog_in   = '0;
         end
      end
      if ((state_ff == ahs_pkg::ST_DIV_RUN) && div_done) begin
         target_in = ahs_pkg::sat36(div_sum);
      end
      if ((state_ff == ahs_pkg::ST_MUL1_RUN) && mul_done) begin
         prog_in = new_prog;
      end
      if ((state_ff == ahs_pkg::ST_MUL2_RUN) && mul_done) begin
         target_in = ahs_pkg::sat36(lift_sum);
         if (prog_ff >= cfg.thresh) begin
            active_in = 1'b0;
            base_in   = '0;
            prog_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b0;
         target_ff <= ahs_pkg::TARGET_RST;
         active_ff <= 1'b0;
         base_ff   <= '0;
         prog_ff   <= '0;
      end else begin
         prev_ff   <= prev_in;
         target_ff <= target_in;
         active_ff <= active_in;
         base_ff   <= base_in;
         prog_ff   <= prog_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      upd_ff   <= upd_in;
      climb_ff <= climb_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, active_ff, upd_ff, target_ff, req_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/ahs_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahs_csr: configuration registers
// APB-style register file holding sensitivity and take-off settings.
// ----------------------------------------------------------------------------
module ahs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ahs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ahs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ahs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output ahs_pkg::cfg_type                  cfg
);

   ahs_pkg::cfg_type     cfg_ff;
   ahs_pkg::cfg_type     cfg_in;
   ahs_pkg::csr_idx_type idx;
   logic                 wr_en;

   assign idx   = ahs_pkg::csr_idx_type'(csr_paddr[ahs_pkg::CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            ahs_pkg::CSR_SENS:   cfg_in.sens   = csr_pwdata[30:0];
            ahs_pkg::CSR_TO_EN:  cfg_in.to_en  = csr_pwdata[0];
            ahs_pkg::CSR_ALPHA:  cfg_in.alpha  = csr_pwdata[15:0];
            ahs_pkg::CSR_ADJUST: cfg_in.adjust = csr_pwdata[30:0];
            ahs_pkg::CSR_THRESH: cfg_in.thresh = csr_pwdata[16:0];
            default:             cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sens   <= ahs_pkg::SENS_RST;
         cfg_ff.to_en  <= ahs_pkg::TO_EN_RST;
         cfg_ff.alpha  <= ahs_pkg::ALPHA_RST;
         cfg_ff.adjust <= ahs_pkg::ADJUST_RST;
         cfg_ff.thresh <= ahs_pkg::THRESH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      unique case (idx)
         ahs_pkg::CSR_SENS:   csr_prdata = {1'b0, cfg_ff.sens};
         ahs_pkg::CSR_TO_EN:  csr_prdata = {31'd0, cfg_ff.to_en};
         ahs_pkg::CSR_ALPHA:  csr_prdata = {16'd0, cfg_ff.alpha};
         ahs_pkg::CSR_ADJUST: csr_prdata = {1'b0, cfg_ff.adjust};
         ahs_pkg::CSR_THRESH: csr_prdata = {15'd0, cfg_ff.thresh};
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== design/ahs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahs_div: bit-serial restoring divider
// Unsigned 48 by 31 bit division, one quotient bit shifted in per cycle.
// ----------------------------------------------------------------------------
module ahs_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ahs_pkg::DIV_N_W-1:0]      dividend,
   input  logic [ahs_pkg::DIV_D_W-1:0]      divisor,
   output logic                             done,
   output logic [ahs_pkg::DIV_N_W-1:0]      quotient
);

   logic [ahs_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [ahs_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [ahs_pkg::DIV_D_W-1:0]   den_ff, den_in;
   logic [ahs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ahs_pkg::DIV_D_W:0]     shifted;
   logic [ahs_pkg::DIV_D_W+1:0]   diff;
   logic                          fits;

   // one trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[ahs_pkg::DIV_N_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[ahs_pkg::DIV_D_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = ahs_pkg::DIV_CNT_W'(ahs_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ahs_pkg::DIV_D_W-1:0] : shifted[ahs_pkg::DIV_D_W-1:0];
         quo_in = {quo_ff[ahs_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/ahs_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahs_mul: bit-serial shift-add multiplier
// Unsigned 31 by 17 bit product, one multiplier bit consumed per cycle.
// ----------------------------------------------------------------------------
module ahs_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ahs_pkg::MUL_A_W-1:0]      mcand,
   input  logic [ahs_pkg::MUL_B_W-1:0]      mplier,
   output logic                             done,
   output logic [ahs_pkg::MUL_P_W-1:0]      product
);

   logic [ahs_pkg::MUL_A_W-1:0]   hi_ff, hi_in;
   logic [ahs_pkg::MUL_B_W-1:0]   lo_ff, lo_in;
   logic [ahs_pkg::MUL_A_W-1:0]   mc_ff, mc_in;
   logic [ahs_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ahs_pkg::MUL_A_W:0]     sum;

   // add multiplicand when the low multiplier bit is set, then shift right
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : '0);

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = mplier;
         mc_in   = mcand;
         cnt_in  = ahs_pkg::MUL_CNT_W'(ahs_pkg::MUL_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[ahs_pkg::MUL_A_W:1];
         lo_in  = {sum[0], lo_ff[ahs_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mc_ff <= mc_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== dv/altitude_hold_setpoint_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_hold_setpoint_test: self-checking bench of the altitude hold block
// A table of directed ticks and register writes runs first, then phases of
// random hold sequences under changing register settings. Every result item
// is checked field by field against its table entry or a local model of the
// setpoint logic, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module altitude_hold_setpoint_test;

   // one input tick, hold_request in the lowest bit
   typedef struct packed {
      logic        tumbled;
      logic        at_rest;
      logic [31:0] measured_alt;
      logic [31:0] pilot_climb;
      logic        hold_request;
   } tick_type;

   // one result item, hold_active in the lowest bit
   typedef struct packed {
      logic        takeoff_running;
      logic        is_update;
      logic [31:0] setpoint_alt;
      logic        hold_active;
   } result_type;

   typedef struct {
      bit          is_csr;
      int unsigned idx;
      logic [31:0] val;
      tick_type    tick;
      bit          typed;
      result_type  want;
   } tab_row_type;

   localparam int unsigned RES_W         = $bits(result_type);
   localparam int unsigned UNMAPPED_A    = 5;
   localparam int unsigned UNMAPPED_B    = 7;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned HOLD_OFF_CYC  = 400;
   localparam int unsigned DRAIN_CYC     = 60;
   localparam int unsigned PRINT_CAP     = 100;
   localparam longint      S32_HI        = 64'sd2147483647;
   localparam longint      S32_LO        = -64'sd2147483648;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ahs_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ahs_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [ahs_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [ahs_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [ahs_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   altitude_hold_setpoint uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model copy of the registers
   longint unsigned cfg_sens   = ahs_pkg::SENS_RST;
   bit              cfg_en     = ahs_pkg::TO_EN_RST;
   longint unsigned cfg_alpha  = ahs_pkg::ALPHA_RST;
   longint unsigned cfg_adjust = ahs_pkg::ADJUST_RST;
   longint unsigned cfg_thresh = ahs_pkg::THRESH_RST;

   // model copy of the state
   bit              hold_seen  = 1'b0;
   longint          tgt_alt    = -64'sd65536;
   bit              climb_on   = 1'b0;
   longint          climb_base = 0;
   longint unsigned climb_prog = 0;

   result_type  pending_q[$];
   tab_row_type dir_tab[$];

   int unsigned mismatches   = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned csr_writes   = 0;
   int unsigned climbs_begun = 0;
   int unsigned climbs_ended = 0;
   int unsigned idle_cycles  = 0;
   bit          no_gaps      = 1'b0;
   bit          stall_req    = 1'b0;

   function automatic longint clamp_s32(longint v);
      if (v > S32_HI) begin
         return S32_HI;
      end
      if (v < S32_LO) begin
         return S32_LO;
      end
      return v;
   endfunction

   // next result of the setpoint logic for one tick, advances model state
   function automatic result_type predict_setpoint(tick_type t);
      result_type      r;
      bit              rise;
      longint          sens;
      longint          delta;
      longint unsigned p;
      longint unsigned lift;
      rise        = t.hold_request && !hold_seen;
      hold_seen   = t.hold_request;
      r.is_update = 1'b0;
      if (t.hold_request) begin
         if (rise) begin
            tgt_alt = longint'($signed(t.measured_alt));
         end else begin
            sens = longint'(cfg_sens);
            if (sens < 1) begin
               sens = 1;
            end
            delta       = (longint'($signed(t.pilot_climb)) * 64'sd65536) / sens;
            tgt_alt     = clamp_s32(tgt_alt + delta);
            r.is_update = 1'b1;
         end
         // climb starts only on the activation tick, at rest and upright
         if (!climb_on && cfg_en && t.at_rest && !t.tumbled && rise) begin
            climb_on   = 1'b1;
            climb_base = tgt_alt;
            climb_prog = 0;
            climbs_begun++;
         end
         // exponential climb overrides the pilot command
         if (climb_on) begin
            p          = climb_prog * cfg_alpha + (64'd65536 - cfg_alpha) * 64'd65536;
            climb_prog = (p + 64'd32768) >> 16;
            lift       = (climb_prog * cfg_adjust + 64'd32768) >> 16;
            tgt_alt    = clamp_s32(climb_base + longint'(lift));
            if (climb_prog >= cfg_thresh) begin
               climb_on   = 1'b0;
               climb_base = 0;
               climb_prog = 0;
               climbs_ended++;
            end
         end
      end
      r.hold_active     = t.hold_request;
      r.setpoint_alt    = tgt_alt[31:0];
      r.takeoff_running = climb_on;
      return r;
   endfunction

   function automatic tab_row_type tick_row(bit h, logic [31:0] climb, logic [31:0] meas,
                                            bit rest, bit tumb);
      tab_row_type r;
      r = '{default: '0};
      r.tick.hold_request = h;
      r.tick.pilot_climb  = climb;
      r.tick.measured_alt = meas;
      r.tick.at_rest      = rest;
      r.tick.tumbled      = tumb;
      return r;
   endfunction

   function automatic tab_row_type with_want(tab_row_type r, logic [31:0] sp, bit upd,
                                             bit run);
      r.typed                = 1'b1;
      r.want.hold_active     = r.tick.hold_request;
      r.want.setpoint_alt    = sp;
      r.want.is_update       = upd;
      r.want.takeoff_running = run;
      return r;
   endfunction

   function automatic tab_row_type csr_row(int unsigned idx, logic [31:0] v);
      tab_row_type r;
      r        = '{default: '0};
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.val    = v;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_CAP) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   // offer one tick, then log the expected result once it is taken
   task automatic push_tick(tick_type t, bit typed, result_type want);
      int unsigned gap;
      result_type  pred;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ahs_pkg::REQ_DATA_W'(t);
      do @(posedge clock); while (!req_tready);
      pred = predict_setpoint(t);
      pending_q.push_back(typed ? want : pred);
      items_sent++;
   endtask

   // drop valid and wait until every result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(int unsigned idx, logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ahs_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         ahs_pkg::CSR_SENS:   cfg_sens   = v & 32'h7FFF_FFFF;
         ahs_pkg::CSR_TO_EN:  cfg_en     = v[0];
         ahs_pkg::CSR_ALPHA:  cfg_alpha  = v & 32'h0000_FFFF;
         ahs_pkg::CSR_ADJUST: cfg_adjust = v & 32'h7FFF_FFFF;
         ahs_pkg::CSR_THRESH: cfg_thresh = v & 32'h0001_FFFF;
         default: ;
      endcase
      csr_writes++;
   endtask

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // result receiver with random gaps and one long hold-off
   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (stall_req) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYC) @(negedge clock);
            stall_req = 1'b0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[RES_W-1:0]);
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing pending", got));
         end else begin
            want = pending_q.pop_front();
            if (got.hold_active !== want.hold_active)
               report_mismatch($sformatf("hold_active %b want %b",
                                         got.hold_active, want.hold_active));
            if (got.setpoint_alt !== want.setpoint_alt)
               report_mismatch($sformatf("setpoint_alt %h want %h",
                                         got.setpoint_alt, want.setpoint_alt));
            if (got.is_update !== want.is_update)
               report_mismatch($sformatf("is_update %b want %b",
                                         got.is_update, want.is_update));
            if (got.takeoff_running !== want.takeoff_running)
               report_mismatch($sformatf("takeoff_running %b want %b",
                                         got.takeoff_running, want.takeoff_running));
            results_seen++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      tick_type    t;
      logic [31:0] v;
      int unsigned seg_left;
      bit          seg_hold;
      bit          seg_first;
      int unsigned n;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      seg_left    = 0;
      seg_hold    = 1'b0;
      seg_first   = 1'b0;

      // directed ticks and register writes
      dir_tab.push_back(with_want(tick_row(0, 0, 0, 0, 0), ahs_pkg::TARGET_RST, 0, 0));
      dir_tab.push_back(with_want(tick_row(1, 32'h7FFF_FFFF, 32'h1234_0000, 0, 0),
                                  32'h1234_0000, 0, 0));
      dir_tab.push_back(tick_row(1, 32'h7FFF_FFFF, 32'h0, 1, 0));
      dir_tab.push_back(tick_row(1, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1));
      dir_tab.push_back(tick_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
      // tumbled on activation: no climb
      dir_tab.push_back(with_want(tick_row(1, 0, 32'h7FFF_FFFF, 1, 1), 32'h7FFF_FFFF, 0, 0));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_SENS, 32'd1));
      dir_tab.push_back(with_want(tick_row(1, 32'h7FFF_FFFF, 0, 0, 0), 32'h7FFF_FFFF, 1, 0));
      dir_tab.push_back(with_want(tick_row(1, 32'h8000_0000, 0, 0, 0), 32'h8000_0000, 1, 0));
      dir_tab.push_back(with_want(tick_row(1, 32'h8000_0000, 0, 0, 0), 32'h8000_0000, 1, 0));
      // zero sensitivity acts as one
      dir_tab.push_back(csr_row(ahs_pkg::CSR_SENS, 32'd0));
      dir_tab.push_back(with_want(tick_row(1, 32'd1, 0, 0, 0), 32'h8001_0000, 1, 0));
      dir_tab.push_back(tick_row(0, 32'd5, 32'd7, 0, 0));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_SENS, ahs_pkg::SENS_RST));
      // take-off with reset settings
      dir_tab.push_back(tick_row(1, 32'd0, 32'd0, 1, 0));
      dir_tab.push_back(tick_row(1, 32'h7FFF_FFFF, 32'd0, 1, 0));
      dir_tab.push_back(tick_row(0, 32'd0, 32'd0, 1, 0));
      // disabled take-off keeps a running climb
      dir_tab.push_back(csr_row(ahs_pkg::CSR_TO_EN, 32'd0));
      dir_tab.push_back(tick_row(1, 32'd0, 32'h8000_0000, 1, 0));
      dir_tab.push_back(tick_row(1, 32'hFFFF_FFFF, 32'd0, 0, 0));
      // zero alpha jumps to full, zero threshold ends at once
      dir_tab.push_back(csr_row(ahs_pkg::CSR_ALPHA, 32'd0));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_THRESH, 32'd0));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_TO_EN, 32'd1));
      dir_tab.push_back(tick_row(1, 32'd0, 32'd0, 0, 0));
      dir_tab.push_back(tick_row(0, 32'd0, 32'd0, 0, 0));
      dir_tab.push_back(with_want(tick_row(1, 0, 32'h7FFF_FFFF, 1, 0), 32'h7FFF_FFFF, 0, 0));
      // largest adjust, slowest alpha, full-scale threshold
      dir_tab.push_back(csr_row(ahs_pkg::CSR_ADJUST, 32'h7FFF_FFFF));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_ALPHA, 32'hFFFF));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_THRESH, 32'h1_0000));
      dir_tab.push_back(tick_row(0, 32'd0, 32'd0, 0, 0));
      dir_tab.push_back(tick_row(1, 32'd0, 32'h8000_0000, 1, 0));
      dir_tab.push_back(tick_row(1, 32'h7FFF_FFFF, 32'd0, 0, 0));
      // threshold out of reach: climb never ends
      dir_tab.push_back(csr_row(ahs_pkg::CSR_THRESH, 32'h1_FFFF));
      dir_tab.push_back(csr_row(ahs_pkg::CSR_ALPHA, 32'd0));
      dir_tab.push_back(tick_row(1, 32'd0, 32'd0, 0, 0));
      dir_tab.push_back(tick_row(1, 32'h8000_0000, 32'd0, 0, 1));
      // writes to unmapped registers change nothing
      dir_tab.push_back(csr_row(UNMAPPED_A, 32'd0));
      dir_tab.push_back(csr_row(UNMAPPED_B, 32'hFFFF_FFFF));
      dir_tab.push_back(tick_row(1, 32'd0, 32'd0, 1, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) begin
            wait_idle();
            csr_write(dir_tab[i].idx, dir_tab[i].val);
         end else begin
            push_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < 10; ph++) begin
         wait_idle();
         if (ph == 0) begin
            csr_write(ahs_pkg::CSR_SENS, ahs_pkg::SENS_RST);
            csr_write(ahs_pkg::CSR_TO_EN, ahs_pkg::TO_EN_RST);
            csr_write(ahs_pkg::CSR_ALPHA, ahs_pkg::ALPHA_RST);
            csr_write(ahs_pkg::CSR_ADJUST, ahs_pkg::ADJUST_RST);
            csr_write(ahs_pkg::CSR_THRESH, ahs_pkg::THRESH_RST);
         end else begin
            case ($urandom_range(0, 5))
               0:       v = 32'd0;
               1:       v = 32'd1;
               2:       v = $urandom_range(1, 65536);
               3:       v = $urandom;
               4:       v = 32'h7FFF_FFFF;
               default: v = $urandom_range(65536, 20000000);
            endcase
            csr_write(ahs_pkg::CSR_SENS, v);
            v    = $urandom;
            v[0] = ($urandom_range(0, 3) != 0);
            csr_write(ahs_pkg::CSR_TO_EN, v);
            case ($urandom_range(0, 4))
               0:       v = 32'd0;
               1:       v = 32'hFFFF;
               2:       v = $urandom;
               default: v = $urandom_range(50000, 65000);
            endcase
            csr_write(ahs_pkg::CSR_ALPHA, v);
            case ($urandom_range(0, 3))
               0:       v = 32'd0;
               1:       v = 32'h7FFF_FFFF;
               2:       v = $urandom;
               default: v = $urandom_range(0, 32'h0010_0000);
            endcase
            csr_write(ahs_pkg::CSR_ADJUST, v);
            case ($urandom_range(0, 5))
               0:       v = 32'd0;
               1:       v = 32'h1_0000;
               2:       v = 32'h1_FFFF;
               3:       v = $urandom;
               default: v = $urandom_range(40000, 65000);
            endcase
            csr_write(ahs_pkg::CSR_THRESH, v);
         end
         no_gaps = (ph % 4 == 3);
         if (ph == 5) begin
            stall_req = 1'b1;
         end
         n = (ph == 0) ? 200 : 100;
         repeat (n) begin
            // hold segments: long active runs, short release gaps
            if (seg_left == 0) begin
               seg_hold  = !seg_hold;
               seg_left  = seg_hold ? $urandom_range(1, 40) : $urandom_range(1, 4);
               seg_first = 1'b1;
            end
            seg_left--;
            t.hold_request = seg_hold;
            if ($urandom_range(0, 19) == 0) begin
               t.hold_request = !seg_hold;
            end
            t.at_rest   = seg_first ? ($urandom_range(0, 4) != 0)
                                    : ($urandom_range(0, 1) != 0);
            t.tumbled   = ($urandom_range(0, 6) == 0);
            seg_first   = 1'b0;
            case ($urandom_range(0, 5))
               0:       t.pilot_climb = $urandom;
               1:       t.pilot_climb = 32'h7FFF_FFFF;
               2:       t.pilot_climb = 32'h8000_0000;
               3:       t.pilot_climb = 32'd0;
               default: t.pilot_climb = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            endcase
            case ($urandom_range(0, 4))
               0:       t.measured_alt = 32'h7FFF_FFFF;
               1:       t.measured_alt = 32'h8000_0000;
               2:       t.measured_alt = $urandom;
               default: t.measured_alt = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            endcase
            push_tick(t, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYC) @(posedge clock);
      if (pending_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
      end

      $display("covered %0d ticks and %0d register writes, %0d results checked",
               items_sent, csr_writes, results_seen);
      $display("take-off climbs started %0d, finished %0d, mismatches %0d",
               climbs_begun, climbs_ended, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ahs_pkg.sv
design/ahs_csr.sv
design/ahs_div.sv
design/ahs_mul.sv
design/altitude_hold_setpoint.sv
dv/altitude_hold_setpoint_test.sv
